// File: rtl/elsu_pkg.sv
// elsu_pkg: shared widths, access codes, fault codes and register indexes
// for the endian aligned load/store core. No dependencies.
package elsu_pkg;

  // Payload widths
  localparam int FUNC_W  = 2;
  localparam int SIZE_W  = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 64;
  localparam int FAULT_W = 2;
  localparam int LIMIT_W = 17;

  // Memory is split into byte lanes, one row holds one lane byte each
  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int MEM_BYTES_DEF = 65536;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEC_PERMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIMIT = 2'd3;

  localparam logic [LIMIT_W-1:0] VALID_LIMIT_RST = 17'h10000;

  // Access kinds
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;

  // Access sizes
  localparam logic [SIZE_W-1:0] SIZE_1 = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_2 = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_4 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_8 = 2'd3;

  // Fault codes
  localparam logic [FAULT_W-1:0] FLT_NONE    = 2'd0;
  localparam logic [FAULT_W-1:0] FLT_ALIGN   = 2'd1;
  localparam logic [FAULT_W-1:0] FLT_EXEC    = 2'd2;
  localparam logic [FAULT_W-1:0] FLT_MISSING = 2'd3;

  // Byte count minus one for an access size (also the alignment mask)
  function automatic logic [LANE_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
    logic [LANE_W-1:0] m;
    case (size)
      SIZE_1:  m = 3'd0;
      SIZE_2:  m = 3'd1;
      SIZE_4:  m = 3'd3;
      SIZE_8:  m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/elsu_if.sv
// elsu_if: valid/ready channels for access items and result items.
// Depends on elsu_pkg for payload widths.
interface elsu_in_if
  import elsu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] access_size;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, func, access_size, address, write_value, input ready);
  modport sink   (input valid, func, access_size, address, write_value, output ready);
endinterface

interface elsu_out_if
  import elsu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_value;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, read_value, fault, input ready);
  modport sink   (input valid, read_value, fault, output ready);
endinterface

// File: rtl/endian_aligned_load_store_core.sv
// endian_aligned_load_store_core: byte-addressed memory with 1/2/4/8 byte
// accesses, endian assembly, alignment, execute and limit checks.
// Depends on elsu_pkg and the channels in elsu_if.sv.
// Pipeline: two register stages; an accepted item is registered into stage 1
//   and then into the result register, from which the result is offered.
// Throughput: one item per cycle, spanning accesses included; eight byte-lane
//   memories each read or write one row per item, so a span over two rows costs
//   nothing extra. Stalls only come from the result side.
// Reset (synchronous, rst_n low): pipeline emptied, registers to defaults;
//   memory contents are not cleared and no clearing pass is run.
// MEM_BYTES must be a power of two.
module endian_aligned_load_store_core
  import elsu_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  elsu_in_if.sink               in_if,
  elsu_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(MEM_BYTES);
  localparam int EXT_W  = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;
  localparam int ROW_W  = IDX_W - LANE_W;
  localparam int ROWS   = MEM_BYTES / LANES;

  // Configuration registers
  logic               big_endian_r;
  logic               align_check_r;
  logic               exec_permit_r;
  logic [LIMIT_W-1:0] valid_limit_r;

  // Request decode
  logic               in_accept;
  logic               out_free;
  logic [EXT_W-1:0]   addr_ext;
  logic [IDX_W-1:0]   byte_idx;
  logic [ROW_W-1:0]   row_base;
  logic [LANE_W-1:0]  start_lane;
  logic [LANE_W-1:0]  req_mask;
  logic [FAULT_W-1:0] req_fault;
  logic               req_rd;
  logic               req_wr;
  logic [ROW_W-1:0]   lane_row [LANES];
  logic               lane_we  [LANES];
  logic [7:0]         lane_wd  [LANES];
  logic [7:0]         lane_rd_q [LANES];

  // Stage 1 (memory read data is in flight)
  logic               s1_valid_r;
  logic [LANE_W-1:0]  s1_start_r;
  logic [LANE_W-1:0]  s1_mask_r;
  logic               s1_rd_r;
  logic [FAULT_W-1:0] s1_fault_r;
  logic [DATA_W-1:0]  s1_value;

  // Result register
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_value_r;
  logic [FAULT_W-1:0] out_fault_r;

  // Handshake
  assign out_free  = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || out_free;
  assign in_accept = in_if.valid && in_if.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r  <= 1'b0;
      align_check_r <= 1'b1;
      exec_permit_r <= 1'b0;
      valid_limit_r <= VALID_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIG_ENDIAN:  big_endian_r  <= cfg_wdata[0];
        CFG_ALIGN_CHECK: align_check_r <= cfg_wdata[0];
        CFG_EXEC_PERMIT: exec_permit_r <= cfg_wdata[0];
        CFG_VALID_LIMIT: valid_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Address split: byte index modulo memory size, row and starting lane
  assign addr_ext   = EXT_W'(in_if.address);
  assign byte_idx   = addr_ext[IDX_W-1:0];
  assign row_base   = byte_idx[IDX_W-1:LANE_W];
  assign start_lane = byte_idx[LANE_W-1:0];

  // Fault checks; a fetch always moves one byte
  always_comb begin
    req_fault = FLT_NONE;
    req_mask  = size_mask(in_if.access_size);
    req_rd    = 1'b0;
    req_wr    = 1'b0;
    case (in_if.func)
      FUNC_FETCH: begin
        req_mask = size_mask(SIZE_1);
        if (!exec_permit_r) begin
          req_fault = FLT_EXEC;
        end else if (LIMIT_W'(in_if.address) >= valid_limit_r) begin
          req_fault = FLT_MISSING;
        end else begin
          req_rd = 1'b1;
        end
      end
      FUNC_READ, FUNC_WRITE: begin
        if (align_check_r && ((start_lane & req_mask) != '0)) begin
          req_fault = FLT_ALIGN;
        end else begin
          req_rd = (in_if.func == FUNC_READ);
          req_wr = (in_if.func == FUNC_WRITE);
        end
      end
      default: ;
    endcase
  end

  // Per-lane row, write enable and write byte
  always_comb begin
    logic [LANE_W-1:0] ofs;
    logic [LANE_W-1:0] src;
    for (int j = 0; j < LANES; j++) begin
      ofs = LANE_W'(j) - start_lane;
      src = big_endian_r ? (req_mask - ofs) : ofs;
      lane_row[j] = (LANE_W'(j) >= start_lane) ? row_base : row_base + 1'b1;
      lane_we[j]  = in_accept && req_wr && (ofs <= req_mask);
      lane_wd[j]  = in_if.write_value[8*src +: 8];
    end
  end

  // Byte-lane memories: one row read or written per item
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (lane_we[g]) begin
        mem[lane_row[g]] <= lane_wd[g];
      end
      if (in_accept) begin
        lane_rd_q[g] <= mem[lane_row[g]];
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_start_r <= start_lane;
      s1_mask_r  <= req_mask;
      s1_rd_r    <= req_rd;
      s1_fault_r <= req_fault;
    end
  end

  // Rotate lanes into access order and apply byte order
  always_comb begin
    logic [LANE_W-1:0] k;
    logic [LANE_W-1:0] lane;
    s1_value = '0;
    for (int i = 0; i < LANES; i++) begin
      k    = big_endian_r ? (s1_mask_r - LANE_W'(i)) : LANE_W'(i);
      lane = s1_start_r + k;
      if (s1_rd_r && (LANE_W'(i) <= s1_mask_r)) begin
        s1_value[8*i +: 8] = lane_rd_q[lane];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_value_r <= s1_value;
      out_fault_r <= s1_fault_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = out_value_r;
  assign out_if.fault      = out_fault_r;

  // Checks
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_fault_r != FLT_NONE) |-> (out_value_r == '0))
    else $error("faulted result carries a nonzero value");

  a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_if.func == FUNC_WRITE) |=> !s1_rd_r)
    else $error("write item marked as read");

  a_exec_fault: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_if.func == FUNC_FETCH) && !exec_permit_r |=> (s1_fault_r == FLT_EXEC))
    else $error("fetch without permission not faulted");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_fault_r) && $stable(s1_start_r))
    else $error("stage 1 item lost under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

endmodule
